// File: design/rcf_pkg.sv
`timescale 1ns / 1ps

package rcf_pkg;

    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam int PIX_W        = 24;
    localparam int CH_W         = 8;
    localparam int COEF_W       = 16;
    localparam int KROW_W       = 48;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int CFG_IDX_W    = 3;

    localparam int PROD_W = COEF_W + CH_W + 1;
    localparam int SUM_W  = PROD_W + 4;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd512;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;
    localparam logic [KROW_W-1:0]       KERNEL_RESET = 48'h01C7_01C7_01C7;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;

    typedef logic [PIX_W-1:0]            t_pixel;
    typedef logic [8:0][PIX_W-1:0]       t_win;
    typedef logic [2:0][KROW_W-1:0]      t_kernel;

    typedef struct packed {
        logic valid;
        logic first_col;
        logic up_ok;
        logic lo_ok;
        logic emit;
        logic last;
    } t_tick_ctl;

    typedef struct packed {
        logic valid;
        logic last;
    } t_res_ctl;

endpackage

// File: design/rcf_line_buf.sv
`timescale 1ns / 1ps

module rcf_line_buf import rcf_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [2*PIX_W-1:0]   i_wr_data,
    output logic [2*PIX_W-1:0]   o_rd_data
);

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic [AW-1:0]      r_rd_addr;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic [AW-1:0]      r_fwd_addr;
    logic               r_fwd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // The most recent write covers a read of the same entry taken in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fwd_data <= i_wr_data;
            r_fwd_addr <= i_wr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    assign o_rd_data = (r_fwd_valid && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_data;

endmodule

// File: design/rcf_window.sv
`timescale 1ns / 1ps

module rcf_window import rcf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  t_tick_ctl          i_ctl,
    input  t_pixel             i_pix,
    input  logic [2*PIX_W-1:0] i_lines,
    output t_win               o_win,
    output t_res_ctl           o_ctl
);

    t_win     r_win;
    t_win     r_fw;
    t_win     n_win;
    t_win     n_fw;
    t_res_ctl r_ctl;
    t_pixel   col [3];

    always_comb begin
        col[0] = i_ctl.up_ok ? i_lines[2*PIX_W-1:PIX_W] : '0;
        col[1] = i_ctl.lo_ok ? i_lines[PIX_W-1:0] : '0;
        col[2] = i_pix;
        for (int row = 0; row < 3; row++) begin
            n_fw[row*3+0] = r_win[row*3+1];
            n_fw[row*3+1] = r_win[row*3+2];
            n_fw[row*3+2] = i_ctl.first_col ? '0 : col[row];
            if (i_ctl.first_col) begin
                n_win[row*3+0] = '0;
                n_win[row*3+1] = '0;
                n_win[row*3+2] = col[row];
            end else begin
                n_win[row*3+0] = n_fw[row*3+0];
                n_win[row*3+1] = n_fw[row*3+1];
                n_win[row*3+2] = n_fw[row*3+2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_win <= '0;
        end else if (i_ctl.valid) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_fw <= n_fw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid <= i_ctl.valid && i_ctl.emit;
            r_ctl.last  <= i_ctl.last;
        end
    end

    assign o_win = r_fw;
    assign o_ctl = r_ctl;

endmodule

// File: design/rcf_mac.sv
`timescale 1ns / 1ps

module rcf_mac import rcf_pkg::*; #(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_win     i_win,
    input  t_res_ctl i_ctl,
    input  t_kernel  i_kernel,
    output t_res_ctl o_ctl,
    output t_pixel   o_pixel
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] r_prod [3][9];
    logic signed [PROD_W-1:0] n_prod [3][9];
    t_res_ctl                 r_ctl;
    logic signed [SUM_W-1:0]  sum [3];
    logic signed [SUM_W-1:0]  quot [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int kr = 0; kr < 3; kr++) begin
                for (int kc = 0; kc < 3; kc++) begin
                    n_prod[ch][kr*3+kc] =
                        $signed(i_kernel[kr][kc*COEF_W +: COEF_W]) *
                        $signed({1'b0, i_win[(2-kr)*3+(2-kc)][ch*CH_W +: CH_W]});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = ((SUM_W'(r_prod[ch][0]) + SUM_W'(r_prod[ch][1]))
                     + (SUM_W'(r_prod[ch][2]) + SUM_W'(r_prod[ch][3])))
                    + ((SUM_W'(r_prod[ch][4]) + SUM_W'(r_prod[ch][5]))
                     + (SUM_W'(r_prod[ch][6]) + SUM_W'(r_prod[ch][7])))
                    + (SUM_W'(r_prod[ch][8]) + ROUND_HALF);
            quot[ch] = sum[ch] >>> COEF_FRAC_BITS;
            if (sum[ch][SUM_W-1]) begin
                o_pixel[ch*CH_W +: CH_W] = '0;
            end else if (quot[ch] > SUM_W'(255)) begin
                o_pixel[ch*CH_W +: CH_W] = '1;
            end else begin
                o_pixel[ch*CH_W +: CH_W] = quot[ch][CH_W-1:0];
            end
        end
    end

    assign o_ctl = r_ctl;

endmodule

// File: design/rcf_out_fifo.sv
`timescale 1ns / 1ps

module rcf_out_fifo import rcf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [PIX_W:0]     i_data,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [PIX_W:0]     o_data,
    output logic [FIFO_CW-1:0] o_count
);

    logic [PIX_W:0]     r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

endmodule

// File: design/rgb_conv3x3_filter_core.sv
`timescale 1ns / 1ps

// 3x3 convolution of a raster-order BGR pixel stream with zero padding at the frame border.
// The slave stream carries one pixel per request in s_axis_tdata; s_axis_tuser marks a flush
// request, which carries no pixel. A frame of W x H pixels needs W x H pixel requests followed
// by W + 1 flush requests; results lag the input by one row plus one pixel.
// The master stream gives one filtered pixel per result, with m_axis_tlast on the last pixel
// of the frame. Frame size and kernel rows are written through the configuration channel,
// which is always ready; writes must be made while the block is idle, which the block itself
// does not enforce, and a size write restarts the frame.
// A request passes from acceptance to the master side through line store read, window
// update, nine products per channel, then sum, rounding and clamp into an eight-entry output
// queue. One request is accepted every cycle while the receiver keeps up. When the receiver
// stalls, the queue fills and s_axis_tready falls once the queue and the three stages together
// hold eight requests; nothing is dropped.
// Reset restores the default size of 512 x 512 and the kernel of about one ninth per tap,
// empties the queue and returns to the top left of the frame; the line stores are not cleared.

module rgb_conv3x3_filter_core import rcf_pkg::*; #(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // pixel_in
    input  logic                 s_axis_tuser,   // flush
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // pixel_out
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KROW_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = HEIGHT_REG_W + 1;

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    t_kernel                 r_kernel;
    logic [CW-1:0]           r_col;
    logic [HEIGHT_REG_W-1:0] r_row;
    t_tick_ctl               r_s1_ctl;
    t_pixel                  r_s1_pix;
    logic [CW-1:0]           r_s1_addr;

    logic [WW-1:0]           w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic [RW-1:0]           row_x;
    logic [RW-1:0]           h_x;
    logic [WW-1:0]           col_inc;
    logic                    accept;
    logic                    restart;
    t_tick_ctl               tick;
    t_pixel                  pix;
    logic [CW-1:0]           n_col;
    logic [HEIGHT_REG_W-1:0] n_row;

    logic [2*PIX_W-1:0]      lines;
    t_win                    win;
    t_res_ctl                win_ctl;
    t_res_ctl                mac_ctl;
    t_pixel                  mac_pixel;
    logic [FIFO_CW-1:0]      fifo_count;
    logic [FIFO_CW-1:0]      outstanding;
    logic [PIX_W:0]          fifo_out;

    assign o_cfg_ready = 1'b1;
    assign restart = i_cfg_valid &&
                     ((i_cfg_index == REG_FRAME_WIDTH) || (i_cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_kernel <= {3{KERNEL_RESET}};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_width     <= i_cfg_data[WIDTH_REG_W-1:0];
                REG_FRAME_HEIGHT: r_height    <= i_cfg_data[HEIGHT_REG_W-1:0];
                REG_KERNEL_TOP:   r_kernel[0] <= i_cfg_data;
                REG_KERNEL_MID:   r_kernel[1] <= i_cfg_data;
                REG_KERNEL_BOT:   r_kernel[2] <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = HEIGHT_REG_W'(1);
        end else if (r_height > HEIGHT_REG_W'(HEIGHT_LIMIT)) begin
            h_eff = HEIGHT_REG_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_height;
        end
    end

    assign outstanding = FIFO_CW'(r_s1_ctl.valid) + FIFO_CW'(win_ctl.valid)
                       + FIFO_CW'(mac_ctl.valid) + fifo_count;
    assign s_axis_tready = (outstanding < FIFO_CW'(FIFO_DEPTH));
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        row_x          = RW'(r_row);
        h_x            = RW'(h_eff);
        tick.valid     = accept;
        tick.first_col = (r_col == '0);
        tick.up_ok     = (row_x >= RW'(2)) && (row_x < h_x + RW'(2));
        tick.lo_ok     = (row_x >= RW'(1)) && (row_x < h_x + RW'(1));
        tick.emit      = tick.first_col ? tick.up_ok : tick.lo_ok;
        tick.last      = tick.first_col && tick.up_ok && (row_x == h_x + RW'(1));
        pix            = (s_axis_tuser || (row_x >= h_x)) ? '0 : s_axis_tdata;
        col_inc        = WW'(r_col) + WW'(1);
        if (tick.last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc == w_eff) begin
            n_col = '0;
            n_row = r_row + HEIGHT_REG_W'(1);
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= pix;
            r_s1_addr <= r_col;
        end
    end

    rcf_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .i_wr_en   (r_s1_ctl.valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({lines[PIX_W-1:0], r_s1_pix}),
        .o_rd_data (lines)
    );

    rcf_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (restart),
        .i_ctl   (r_s1_ctl),
        .i_pix   (r_s1_pix),
        .i_lines (lines),
        .o_win   (win),
        .o_ctl   (win_ctl)
    );

    rcf_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (win),
        .i_ctl    (win_ctl),
        .i_kernel (r_kernel),
        .o_ctl    (mac_ctl),
        .o_pixel  (mac_pixel)
    );

    rcf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mac_ctl.valid),
        .i_data  ({mac_ctl.last, mac_pixel}),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (fifo_out),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = fifo_out[PIX_W-1:0];
    assign m_axis_tlast = fifo_out[PIX_W];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_ctl.valid |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)))
        else $error("result queue written while full");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < w_eff)
        else $error("column position beyond frame width");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && tick.last && !restart) |=> ((r_row == '0) && (r_col == '0)))
        else $error("position not returned to frame start after last pixel");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mac_ctl.valid && mac_ctl.last) |-> $past(win_ctl.valid && win_ctl.last))
        else $error("frame end result without a matching window stage");

endmodule

// File: tb/rgb_conv3x3_filter_core_tb.sv
`timescale 1ns / 1ps

module rgb_conv3x3_filter_core_tb;
    import rcf_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int FRAC_BITS     = DEF_COEF_FRAC_BITS;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 200;
    localparam int EDGE_ITEMS    = 30;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST   = REG_KERNEL_BOT + 3'd1;
    localparam logic [COEF_W-1:0]    COEF_MAX          = 16'h7FFF;
    localparam logic [COEF_W-1:0]    COEF_MIN          = 16'h8000;
    localparam logic [KROW_W-1:0]    KERNEL_CENTRE_ONE = (KROW_W'(1) << FRAC_BITS) << COEF_W;

    typedef struct packed {
        t_pixel pixel;
        logic   flush;
    } t_pixel_req;

    typedef struct packed {
        t_pixel pixel;
        logic   last;
    } t_filtered_px;

    typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_TOGGLE} t_ready_mode;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [KROW_W-1:0]    i_cfg_data    = '0;

    rgb_conv3x3_filter_core #(
        .MAX_WIDTH     (MAX_W),
        .COEF_FRAC_BITS(FRAC_BITS)
    ) DUT (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state.
    t_pixel                  upper_line [MAX_W];
    t_pixel                  lower_line [MAX_W];
    t_pixel                  window_px [9];
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [KROW_W-1:0]       kernel_rows [3];

    t_pixel_req   pending_pixels [$];
    t_filtered_px expected_pixels [$];
    int unsigned  queued_total = 0;
    int unsigned  mismatches   = 0;
    logic         pressure_phase = 1'b0;

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        return h;
    endfunction

    function automatic void restart_frame();
        int k;
        col_pos = 0;
        row_pos = 0;
        for (k = 0; k < 9; k++) window_px[k] = '0;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [KROW_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH: begin
                width_reg = data[WIDTH_REG_W-1:0];
                restart_frame();
            end
            REG_FRAME_HEIGHT: begin
                height_reg = data[HEIGHT_REG_W-1:0];
                restart_frame();
            end
            REG_KERNEL_TOP: kernel_rows[0] = data;
            REG_KERNEL_MID: kernel_rows[1] = data;
            REG_KERNEL_BOT: kernel_rows[2] = data;
            default: ;
        endcase
    endfunction

    // True convolution: the kernel is applied flipped across the window.
    function automatic t_pixel convolve_window();
        t_pixel                    res;
        longint                    acc;
        longint                    q;
        logic signed [COEF_W-1:0]  coef;
        int                        ch, kr, kc;
        res = '0;
        for (ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (kr = 0; kr < 3; kr++) begin
                for (kc = 0; kc < 3; kc++) begin
                    coef = kernel_rows[kr][COEF_W*kc +: COEF_W];
                    acc += longint'(coef)
                         * longint'(window_px[(2-kr)*3 + (2-kc)][CH_W*ch +: CH_W]);
                end
            end
            acc += longint'(1) << (FRAC_BITS - 1);
            if (acc < 0) begin
                q = 0;
            end else begin
                q = acc >>> FRAC_BITS;
                if (q > 255) q = 255;
            end
            res[CH_W*ch +: CH_W] = q[CH_W-1:0];
        end
        return res;
    endfunction

    function automatic void predict_tick(input t_pixel px_in, input logic flush);
        int unsigned  w, h, r, c;
        t_pixel       p, a, b;
        t_pixel       col [3];
        logic         emit, last;
        t_filtered_px res;
        int           k;
        w    = active_width();
        h    = active_height();
        r    = row_pos;
        c    = col_pos;
        emit = 1'b0;
        last = 1'b0;
        res  = '0;
        if (c >= w) c = 0;
        p = (flush || r >= h) ? '0 : px_in;
        a = upper_line[c];
        b = lower_line[c];
        upper_line[c] = b;
        lower_line[c] = p;
        col[0] = (r >= 2 && r - 2 < h) ? a : '0;
        col[1] = (r >= 1 && r - 1 < h) ? b : '0;
        col[2] = p;
        if (c == 0) begin
            // The right border column is padding; the new row starts with zero columns.
            for (k = 0; k < 3; k++) begin
                window_px[k*3]   = window_px[k*3+1];
                window_px[k*3+1] = window_px[k*3+2];
                window_px[k*3+2] = '0;
            end
            if (r >= 2 && r - 2 < h) begin
                emit      = 1'b1;
                last      = (r - 2 == h - 1);
                res.pixel = convolve_window();
            end
            for (k = 0; k < 3; k++) begin
                window_px[k*3]   = '0;
                window_px[k*3+1] = '0;
                window_px[k*3+2] = col[k];
            end
        end else begin
            for (k = 0; k < 3; k++) begin
                window_px[k*3]   = window_px[k*3+1];
                window_px[k*3+1] = window_px[k*3+2];
                window_px[k*3+2] = col[k];
            end
            if (r >= 1 && r - 1 < h) begin
                emit      = 1'b1;
                res.pixel = convolve_window();
            end
        end
        if (last) begin
            r = 0;
            c = 0;
        end else begin
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
        end
        row_pos = r % (1 << HEIGHT_REG_W);
        col_pos = c;
        if (emit) begin
            res.last = last;
            expected_pixels.push_back(res);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    // Driver: bursts of requests from the pending queue with random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    t_pixel_req  next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_tick(s_axis_tdata, s_axis_tuser);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    next_req       = pending_pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_req.pixel;
                    s_axis_tuser  <= next_req.flush;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                  : $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: changing stall patterns, and one long hold-off while the sender keeps going.
    t_ready_mode ready_mode = READY_ALWAYS;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    logic        hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (pressure_phase && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= t_ready_mode'($urandom_range(0, 3));
                mode_left  <= $urandom_range(8, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                READY_ALWAYS: m_axis_tready <= 1'b1;
                READY_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:      m_axis_tready <= !m_axis_tready;
            endcase
        end
    end

    t_filtered_px want_px;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected pixel", 32'(m_axis_tdata), '0);
            end else begin
                want_px = expected_pixels.pop_front();
                if (m_axis_tdata !== want_px.pixel)
                    report_mismatch("pixel_out", 32'(m_axis_tdata), 32'(want_px.pixel));
                if (m_axis_tlast !== want_px.last)
                    report_mismatch("frame_end", 32'(m_axis_tlast), 32'(want_px.last));
            end
        end
    end

    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("rgb_conv3x3_filter_core_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [KROW_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_config(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_item(input t_pixel px, input logic flush);
        pending_pixels.push_back('{pixel: px, flush: flush});
        queued_total++;
    endfunction

    function automatic t_pixel rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return t_pixel'($urandom);
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] rand_kernel_row();
        logic [KROW_W-1:0] row;
        int                k;
        row = KROW_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: ;
            1: for (k = 0; k < 3; k++)
                   row[COEF_W*k +: COEF_W] = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            default: for (k = 0; k < 3; k++)
                   row[COEF_W*k +: COEF_W] = COEF_W'($urandom_range(0, 1200)) - 16'd600;
        endcase
        return row;
    endfunction

    // A noisy frame has some flush requests inside it and some pixels in its drain.
    task automatic queue_frame(input bit noisy);
        int unsigned w, h;
        w = active_width();
        h = active_height();
        repeat (w * h) queue_item(rand_pixel(), noisy && $urandom_range(0, 9) == 0);
        repeat (w + 1) queue_item(rand_pixel(), !(noisy && $urandom_range(0, 6) == 0));
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        logic [KROW_W-1:0] data;
        data = KROW_W'({$urandom, $urandom});
        if (idx == REG_FRAME_WIDTH) data[WIDTH_REG_W-1:0] = WIDTH_REG_W'(value);
        else data[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'(value);
        write_register(idx, data);
    endtask

    task automatic write_kernels();
        write_register(REG_KERNEL_TOP, rand_kernel_row());
        write_register(REG_KERNEL_MID, rand_kernel_row());
        write_register(REG_KERNEL_BOT, rand_kernel_row());
    endtask

    int unsigned frames;
    bit          must_resize;

    initial begin
        width_reg   = WIDTH_RESET;
        height_reg  = HEIGHT_RESET;
        kernel_rows = '{KERNEL_RESET, KERNEL_RESET, KERNEL_RESET};
        foreach (upper_line[k]) upper_line[k] = '0;
        foreach (lower_line[k]) lower_line[k] = '0;
        restart_frame();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sizes of zero count as one: a single-pixel frame under the reset kernel.
        write_register(REG_FRAME_WIDTH, '0);
        write_register(REG_FRAME_HEIGHT, '0);
        queue_item('1, 1'b0);
        queue_item('1, 1'b1);
        queue_item('0, 1'b1);
        wait_idle();

        // Pass-through kernel, a flush inside the frame and a pixel during the drain.
        write_register(REG_KERNEL_TOP, '0);
        write_register(REG_KERNEL_MID, KERNEL_CENTRE_ONE);
        write_register(REG_KERNEL_BOT, '0);
        write_register(REG_FRAME_WIDTH, KROW_W'(3));
        write_register(REG_FRAME_HEIGHT, KROW_W'(2));
        queue_item('0, 1'b0);
        queue_item('1, 1'b0);
        queue_item(24'h12_3456, 1'b0);
        queue_item(24'hC3_3C96, 1'b1);
        queue_item(24'hA5_A5A5, 1'b0);
        queue_item(24'h5A_5A5A, 1'b0);
        queue_item('0, 1'b1);
        queue_item('1, 1'b0);
        queue_item('1, 1'b1);
        queue_item('0, 1'b1);
        wait_idle();

        // Extreme coefficients, and an unknown register index that must be ignored.
        write_register(REG_SPARE_FIRST, '1);
        write_register(REG_KERNEL_TOP, {3{COEF_MAX}});
        write_register(REG_KERNEL_MID, {COEF_MIN, COEF_MAX, 16'h0001});
        write_register(REG_KERNEL_BOT, {3{COEF_MIN}});
        write_register(REG_FRAME_WIDTH, KROW_W'(2));
        write_register(REG_FRAME_HEIGHT, KROW_W'(2));
        queue_item('1, 1'b0);
        queue_item('0, 1'b0);
        queue_item('1, 1'b0);
        queue_item(24'h00_FF00, 1'b0);
        repeat (3) queue_item('1, 1'b1);
        wait_idle();

        // A frame cut short; the next size write restarts it.
        write_register(REG_FRAME_HEIGHT, KROW_W'(3));
        repeat (4) queue_item(rand_pixel(), 1'b0);
        wait_idle();
        must_resize = 1'b1;

        while (queued_total < RANDOM_ITEMS) begin
            if (must_resize || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       write_size(REG_FRAME_WIDTH, 0);
                    1:       write_size(REG_FRAME_WIDTH, $urandom_range(9, 24));
                    default: write_size(REG_FRAME_WIDTH, $urandom_range(1, 8));
                endcase
            end
            if ($urandom_range(0, 2) == 0)
                write_size(REG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ? 0
                                                                       : $urandom_range(1, 6));
            if ($urandom_range(0, 1) == 0) write_register(REG_KERNEL_TOP, rand_kernel_row());
            if ($urandom_range(0, 1) == 0) write_register(REG_KERNEL_MID, rand_kernel_row());
            if ($urandom_range(0, 1) == 0) write_register(REG_KERNEL_BOT, rand_kernel_row());
            if ($urandom_range(0, 9) == 0)
                write_register(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)),
                               KROW_W'({$urandom, $urandom}));
            frames = $urandom_range(1, 3);
            repeat (frames) queue_frame($urandom_range(0, 2) == 0);
            must_resize = 1'b0;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, active_width() * (active_height() + 1)))
                    queue_item(rand_pixel(), $urandom_range(0, 3) == 0);
                must_resize = 1'b1;
            end
            wait_idle();
        end

        // Long receiver hold-off while a tall frame keeps the input busy.
        write_size(REG_FRAME_WIDTH, 4);
        write_size(REG_FRAME_HEIGHT, 20);
        write_kernels();
        queue_frame(1'b1);
        pressure_phase = 1'b1;
        wait_idle();

        // Largest sizes, written both exactly and out of range.
        write_size(REG_FRAME_WIDTH, MAX_W);
        write_size(REG_FRAME_HEIGHT, 1);
        write_kernels();
        repeat (EDGE_ITEMS) queue_item(rand_pixel(), 1'b0);
        wait_idle();

        write_size(REG_FRAME_WIDTH, (1 << WIDTH_REG_W) - 1);
        write_size(REG_FRAME_HEIGHT, 0);
        repeat (EDGE_ITEMS) queue_item(rand_pixel(), $urandom_range(0, 9) == 0);
        wait_idle();

        write_size(REG_FRAME_WIDTH, 0);
        write_size(REG_FRAME_HEIGHT, HEIGHT_LIMIT);
        write_kernels();
        repeat (EDGE_ITEMS) queue_item(rand_pixel(), $urandom_range(0, 9) == 0);
        wait_idle();

        write_size(REG_FRAME_WIDTH, 1);
        write_size(REG_FRAME_HEIGHT, (1 << HEIGHT_REG_W) - 1);
        repeat (EDGE_ITEMS) queue_item(rand_pixel(), 1'b0);
        wait_idle();

        if (mismatches == 0) begin
            $display("rgb_conv3x3_filter_core_tb passed");
        end else begin
            $display("rgb_conv3x3_filter_core_tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/rcf_pkg.sv
design/rcf_line_buf.sv
design/rcf_window.sv
design/rcf_mac.sv
design/rcf_out_fifo.sv
design/rgb_conv3x3_filter_core.sv
tb/rgb_conv3x3_filter_core_tb.sv
